// ===== src/vbsp_pkg.sv =====
package vbsp_pkg;

    localparam int MAX_RADIUS    = 2;
    localparam int CELL_CAPACITY = 128;
    localparam int SPAN          = 2 * MAX_RADIUS + 1;
    localparam int MASK_W        = SPAN;
    localparam int IDX_W         = $clog2(SPAN);
    localparam int CNT_W         = 7;

    localparam logic [1:0] SHAPE_CUBE   = 2'd0;
    localparam logic [1:0] SHAPE_SPHERE = 2'd1;
    localparam logic [1:0] SHAPE_CYL    = 2'd2;

    localparam logic [1:0] SIZE_LARGEST = 2'd2;

    localparam logic [1:0] FILL_SOLID = 2'd0;
    localparam logic [1:0] FILL_SHELL = 2'd1;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [2:0] GUIDE_PLANE_X = 3'd4;
    localparam logic [2:0] GUIDE_PLANE_Y = 3'd5;
    localparam logic [2:0] GUIDE_PLANE_Z = 3'd6;
    localparam logic [2:0] GUIDE_INVALID = 3'd7;

    localparam logic [3:0] ST_PLANNED   = 4'd0;
    localparam logic [3:0] ST_BAD_SHAPE = 4'd1;
    localparam logic [3:0] ST_BAD_SIZE  = 4'd2;
    localparam logic [3:0] ST_BAD_FILL  = 4'd3;
    localparam logic [3:0] ST_BAD_AXIS  = 4'd4;
    localparam logic [3:0] ST_BAD_GUIDE = 4'd5;
    localparam logic [3:0] ST_OVERFLOW  = 4'd6;
    localparam logic [3:0] ST_CAPACITY  = 4'd7;
    localparam logic [3:0] ST_EMPTY     = 4'd8;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        logic [3:0]         status;
        logic [1:0]         radius;
        logic [1:0]         shape;
        logic [1:0]         fill;
        logic [1:0]         axis;
        logic [2:0]         guide;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
    } job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SCAN,
        B_CHECK,
        B_EMIT,
        B_SUM
    } back_state_t;

    function automatic logic [3:0] sq_f(input logic signed [3:0] v);
        logic [3:0] sq;
        case (v)
            4'sd0:          sq = 4'd0;
            4'sd1, -4'sd1:  sq = 4'd1;
            4'sd2, -4'sd2:  sq = 4'd4;
            4'sd3, -4'sd3:  sq = 4'd9;
            default:        sq = 4'd0;
        endcase
        return sq;
    endfunction

    // True when the offset lies inside the solid shape before any shell test.
    function automatic logic filled_f(input logic [1:0] shape, input logic [1:0] axis,
                                      input logic [2:0] guide, input logic [1:0] radius,
                                      input logic signed [3:0] dx,
                                      input logic signed [3:0] dy,
                                      input logic signed [3:0] dz);
        logic signed [3:0] rs;
        logic [4:0]        rr;
        logic [4:0]        sx;
        logic [4:0]        sy;
        logic [4:0]        sz;
        logic              ok;
        rs = signed'({2'b00, radius});
        rr = {1'b0, sq_f(rs)};
        sx = {1'b0, sq_f(dx)};
        sy = {1'b0, sq_f(dy)};
        sz = {1'b0, sq_f(dz)};
        ok = (dx >= -rs) && (dx <= rs) && (dy >= -rs) && (dy <= rs) &&
             (dz >= -rs) && (dz <= rs);
        if (guide == GUIDE_PLANE_X && dx != 4'sd0) ok = 1'b0;
        if (guide == GUIDE_PLANE_Y && dy != 4'sd0) ok = 1'b0;
        if (guide == GUIDE_PLANE_Z && dz != 4'sd0) ok = 1'b0;
        case (shape)
            SHAPE_CUBE:   ;
            SHAPE_SPHERE: if (sx + sy + sz > rr) ok = 1'b0;
            SHAPE_CYL:
            begin
                case (axis)
                    AXIS_X:  if (sy + sz > rr) ok = 1'b0;
                    AXIS_Y:  if (sx + sz > rr) ok = 1'b0;
                    AXIS_Z:  if (sx + sy > rr) ok = 1'b0;
                    default: ok = 1'b0;
                endcase
            end
            default:      ok = 1'b0;
        endcase
        return ok;
    endfunction

    // x-mask of one (dz,dy) row; bit i stands for dx = i - radius.
    function automatic logic [MASK_W-1:0] row_mask_f(input job_t job,
                                                     input logic [IDX_W-1:0] dy_idx,
                                                     input logic [IDX_W-1:0] dz_idx);
        logic [MASK_W-1:0] m;
        logic signed [3:0] rs;
        logic signed [3:0] dx;
        logic signed [3:0] dy;
        logic signed [3:0] dz;
        logic              fl;
        logic              rim;
        m  = '0;
        rs = signed'({2'b00, job.radius});
        dy = signed'({1'b0, dy_idx}) - rs;
        dz = signed'({1'b0, dz_idx}) - rs;
        for (int i = 0; i < MASK_W; i++)
        begin
            dx  = signed'(4'(i)) - rs;
            fl  = filled_f(job.shape, job.axis, job.guide, job.radius, dx, dy, dz);
            rim = !filled_f(job.shape, job.axis, job.guide, job.radius, dx - 4'sd1, dy, dz) ||
                  !filled_f(job.shape, job.axis, job.guide, job.radius, dx + 4'sd1, dy, dz) ||
                  !filled_f(job.shape, job.axis, job.guide, job.radius, dx, dy - 4'sd1, dz) ||
                  !filled_f(job.shape, job.axis, job.guide, job.radius, dx, dy + 4'sd1, dz) ||
                  !filled_f(job.shape, job.axis, job.guide, job.radius, dx, dy, dz - 4'sd1) ||
                  !filled_f(job.shape, job.axis, job.guide, job.radius, dx, dy, dz + 4'sd1);
            if (job.fill == FILL_SOLID)
                m[i] = fl;
            else if (job.fill == FILL_SHELL)
                m[i] = fl & rim;
            else
                m[i] = 1'b0;
        end
        return m;
    endfunction

    function automatic logic [2:0] pop_f(input logic [MASK_W-1:0] m);
        logic [2:0] n;
        n = '0;
        for (int i = 0; i < MASK_W; i++)
            n = n + 3'(m[i]);
        return n;
    endfunction

    function automatic logic [IDX_W-1:0] low_bit_f(input logic [MASK_W-1:0] m);
        logic [IDX_W-1:0] p;
        p = '0;
        for (int i = MASK_W - 1; i >= 0; i--)
            if (m[i]) p = IDX_W'(i);
        return p;
    endfunction

    function automatic logic [IDX_W-1:0] high_bit_f(input logic [MASK_W-1:0] m);
        logic [IDX_W-1:0] p;
        p = '0;
        for (int i = 0; i < MASK_W; i++)
            if (m[i]) p = IDX_W'(i);
        return p;
    endfunction

endpackage

// ===== src/vbsp_front.sv =====
module vbsp_front
    import vbsp_pkg::*;
(
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         shape,
    input  logic [1:0]         brush_size,
    input  logic [1:0]         fill,
    input  logic [1:0]         axis,
    input  logic [2:0]         guide,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [31:0] center_z,
    input  logic               q_full,
    output logic               push,
    output job_t               push_job
);

    // True when c + off leaves the signed 32-bit range.
    function automatic logic ovf_f(input logic signed [31:0] c, input logic signed [3:0] off);
        logic [32:0] s;
        s = {c[31], c} + 33'(off);
        return s[32] ^ s[31];
    endfunction

    logic [1:0]        radius;
    logic signed [3:0] rs;
    logic signed [3:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
    logic [3:0]        status;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        radius = (int'(brush_size) > MAX_RADIUS) ? 2'(MAX_RADIUS) : brush_size;
        rs     = signed'({2'b00, radius});
        lo_x   = (guide == GUIDE_PLANE_X) ? 4'sd0 : -rs;
        hi_x   = (guide == GUIDE_PLANE_X) ? 4'sd0 : rs;
        lo_y   = (guide == GUIDE_PLANE_Y) ? 4'sd0 : -rs;
        hi_y   = (guide == GUIDE_PLANE_Y) ? 4'sd0 : rs;
        lo_z   = (guide == GUIDE_PLANE_Z) ? 4'sd0 : -rs;
        hi_z   = (guide == GUIDE_PLANE_Z) ? 4'sd0 : rs;
        if (shape > SHAPE_CYL)
            status = ST_BAD_SHAPE;
        else if (brush_size > SIZE_LARGEST)
            status = ST_BAD_SIZE;
        else if (fill > FILL_SHELL)
            status = ST_BAD_FILL;
        else if (axis > AXIS_Z)
            status = ST_BAD_AXIS;
        else if (guide == GUIDE_INVALID)
            status = ST_BAD_GUIDE;
        else if (ovf_f(center_x, lo_x) || ovf_f(center_x, hi_x) ||
                 ovf_f(center_y, lo_y) || ovf_f(center_y, hi_y) ||
                 ovf_f(center_z, lo_z) || ovf_f(center_z, hi_z))
            status = ST_OVERFLOW;
        else
            status = ST_PLANNED;
    end

    always_comb
    begin
        push_job.status = status;
        push_job.radius = radius;
        push_job.shape  = shape;
        push_job.fill   = fill;
        push_job.axis   = axis;
        push_job.guide  = guide;
        push_job.cx     = center_x;
        push_job.cy     = center_y;
        push_job.cz     = center_z;
    end

endmodule

// ===== src/vbsp_queue.sv =====
module vbsp_queue
    import vbsp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic empty,
    output job_t head
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== src/vbsp_back.sv =====
module vbsp_back
    import vbsp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  job_t               q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] coord_x,
    output logic signed [31:0] coord_y,
    output logic signed [31:0] coord_z,
    output logic [4:0]         row_mask,
    output logic signed [31:0] box_max_x,
    output logic signed [31:0] box_max_y,
    output logic signed [31:0] box_max_z,
    output logic [6:0]         cell_count,
    output logic [3:0]         status,
    output logic               last
);

    back_state_t       state_reg, state_next;
    job_t              job_reg;
    logic [3:0]        status_reg;
    logic [31:0]       base_x_reg, base_y_reg, base_z_reg;
    logic [IDX_W-1:0]  dy_reg, dz_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              any_reg;
    logic [IDX_W-1:0]  min_x_reg, min_y_reg, min_z_reg;
    logic [IDX_W-1:0]  max_x_reg, max_y_reg, max_z_reg;

    logic              out_valid_reg, out_valid_next;
    logic [31:0]       coord_x_reg, coord_y_reg, coord_z_reg;
    logic [4:0]        row_mask_reg;
    logic [31:0]       box_max_x_reg, box_max_y_reg, box_max_z_reg;
    logic [6:0]        cell_count_reg;
    logic [3:0]        status_out_reg;
    logic              last_reg;

    logic [MASK_W-1:0] mask;
    logic [IDX_W-1:0]  last_idx;
    logic              row_end, all_end, out_free, row_ok;
    logic [3:0]        final_status;
    logic              advance, load_row, load_sum;
    logic [IDX_W-1:0]  lo_bit, hi_bit;

    assign mask     = row_mask_f(job_reg, dy_reg, dz_reg);
    assign last_idx = IDX_W'({job_reg.radius, 1'b0});
    assign row_end  = (dy_reg == last_idx);
    assign all_end  = row_end && (dz_reg == last_idx);
    assign out_free = !out_valid_reg || !out_stall;
    assign row_ok   = (mask == '0) || out_free;
    assign lo_bit   = low_bit_f(mask);
    assign hi_bit   = high_bit_f(mask);

    always_comb
    begin
        if (int'(count_reg) > CELL_CAPACITY)
            final_status = ST_CAPACITY;
        else if (count_reg == '0)
            final_status = ST_EMPTY;
        else
            final_status = ST_PLANNED;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                    state_next = (q_head.status == ST_PLANNED) ? B_SCAN : B_SUM;
            end
            B_SCAN:
            begin
                if (all_end)
                    state_next = B_CHECK;
            end
            B_CHECK:
            begin
                state_next = (final_status == ST_PLANNED) ? B_EMIT : B_SUM;
            end
            B_EMIT:
            begin
                if (all_end && row_ok)
                    state_next = B_SUM;
            end
            B_SUM:
            begin
                if (out_free)
                    state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        q_pop    = 1'b0;
        advance  = 1'b0;
        load_row = 1'b0;
        load_sum = 1'b0;
        case (state_reg)
            B_IDLE:  q_pop = !q_empty;
            B_SCAN:  advance = 1'b1;
            B_CHECK: ;
            B_EMIT:
            begin
                advance  = row_ok;
                load_row = (mask != '0) && out_free;
            end
            B_SUM:   load_sum = out_free;
            default: ;
        endcase
    end

    always_comb
    begin
        if (load_row || load_sum)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            dy_reg        <= '0;
            dz_reg        <= '0;
            count_reg     <= '0;
            any_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                dy_reg    <= '0;
                dz_reg    <= '0;
                count_reg <= '0;
                any_reg   <= 1'b0;
            end
            else
            begin
                if (advance)
                begin
                    if (all_end)
                    begin
                        dy_reg <= '0;
                        dz_reg <= '0;
                    end
                    else if (row_end)
                    begin
                        dy_reg <= '0;
                        dz_reg <= dz_reg + 1'b1;
                    end
                    else
                    begin
                        dy_reg <= dy_reg + 1'b1;
                    end
                end
                if (state_reg == B_SCAN && mask != '0)
                begin
                    count_reg <= count_reg + CNT_W'(pop_f(mask));
                    any_reg   <= 1'b1;
                end
            end
        end
    end

    // Request data, the running bounding box and the output register.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg    <= q_head;
            status_reg <= q_head.status;
            base_x_reg <= q_head.cx - 32'(q_head.radius);
            base_y_reg <= q_head.cy - 32'(q_head.radius);
            base_z_reg <= q_head.cz - 32'(q_head.radius);
        end
        if (state_reg == B_CHECK)
            status_reg <= final_status;
        if (state_reg == B_SCAN && mask != '0)
        begin
            if (!any_reg || lo_bit < min_x_reg) min_x_reg <= lo_bit;
            if (!any_reg || hi_bit > max_x_reg) max_x_reg <= hi_bit;
            if (!any_reg || dy_reg < min_y_reg) min_y_reg <= dy_reg;
            if (!any_reg || dy_reg > max_y_reg) max_y_reg <= dy_reg;
            if (!any_reg || dz_reg < min_z_reg) min_z_reg <= dz_reg;
            if (!any_reg || dz_reg > max_z_reg) max_z_reg <= dz_reg;
        end
        if (load_row)
        begin
            coord_x_reg    <= base_x_reg;
            coord_y_reg    <= base_y_reg + 32'(dy_reg);
            coord_z_reg    <= base_z_reg + 32'(dz_reg);
            row_mask_reg   <= mask;
            box_max_x_reg  <= '0;
            box_max_y_reg  <= '0;
            box_max_z_reg  <= '0;
            cell_count_reg <= '0;
            status_out_reg <= ST_PLANNED;
            last_reg       <= 1'b0;
        end
        else if (load_sum)
        begin
            row_mask_reg   <= '0;
            status_out_reg <= status_reg;
            last_reg       <= 1'b1;
            if (status_reg == ST_PLANNED)
            begin
                coord_x_reg    <= base_x_reg + 32'(min_x_reg);
                coord_y_reg    <= base_y_reg + 32'(min_y_reg);
                coord_z_reg    <= base_z_reg + 32'(min_z_reg);
                box_max_x_reg  <= base_x_reg + 32'(max_x_reg);
                box_max_y_reg  <= base_y_reg + 32'(max_y_reg);
                box_max_z_reg  <= base_z_reg + 32'(max_z_reg);
                cell_count_reg <= 7'(count_reg);
            end
            else
            begin
                coord_x_reg    <= '0;
                coord_y_reg    <= '0;
                coord_z_reg    <= '0;
                box_max_x_reg  <= '0;
                box_max_y_reg  <= '0;
                box_max_z_reg  <= '0;
                cell_count_reg <= '0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign coord_x    = signed'(coord_x_reg);
    assign coord_y    = signed'(coord_y_reg);
    assign coord_z    = signed'(coord_z_reg);
    assign row_mask   = row_mask_reg;
    assign box_max_x  = signed'(box_max_x_reg);
    assign box_max_y  = signed'(box_max_y_reg);
    assign box_max_z  = signed'(box_max_z_reg);
    assign cell_count = cell_count_reg;
    assign status     = status_out_reg;
    assign last       = last_reg;

endmodule

// ===== src/voxel_brush_stamp_planner_top.sv =====
// Voxel brush stamp planner.
// The input channel (in_valid / in_stall) takes one brush request: shape, size,
// fill, cylinder axis, guide and a signed 32-bit centre cell. The output channel
// (out_valid / out_stall) returns, for a planned request, one row request per
// non-empty (dz,dy) row with its x-mask, in ascending dz then dy, followed by
// a summary request (last = 1) with the cell count, bounding box and status.
// A rejected request returns the summary alone, with a non-zero status.
// The front classifies each request in the cycle it is accepted and places it
// in a two-entry queue, so up to two requests wait while the back is busy.
// The back walks the (2r+1)^2 rows twice: once to count cells and find the
// bounding box, once to emit rows. The first row of a planned request appears
// only after the counting walk is done.
// The output is registered: while out_stall is high the back holds its next
// result, the queue fills and in_stall rises once it holds two requests.
// Reset empties the queue, returns the back to idle and drops out_valid.
module voxel_brush_stamp_planner_top
    import vbsp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         shape,
    input  logic [1:0]         brush_size,
    input  logic [1:0]         fill,
    input  logic [1:0]         axis,
    input  logic [2:0]         guide,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [31:0] center_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] coord_x,
    output logic signed [31:0] coord_y,
    output logic signed [31:0] coord_z,
    output logic [4:0]         row_mask,
    output logic signed [31:0] box_max_x,
    output logic signed [31:0] box_max_y,
    output logic signed [31:0] box_max_z,
    output logic [6:0]         cell_count,
    output logic [3:0]         status,
    output logic               last
);

    // Classified requests pass from the front to the back through the queue.
    logic q_push, q_pop, q_full, q_empty;
    job_t push_job, q_head;

    vbsp_front u_front
    (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .shape      (shape),
        .brush_size (brush_size),
        .fill       (fill),
        .axis       (axis),
        .guide      (guide),
        .center_x   (center_x),
        .center_y   (center_y),
        .center_z   (center_z),
        .q_full     (q_full),
        .push       (q_push),
        .push_job   (push_job)
    );

    vbsp_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    // The back sequences the row scan, the row emission and the summary.
    vbsp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .coord_z    (coord_z),
        .row_mask   (row_mask),
        .box_max_x  (box_max_x),
        .box_max_y  (box_max_y),
        .box_max_z  (box_max_z),
        .cell_count (cell_count),
        .status     (status),
        .last       (last)
    );

endmodule
